@@ rtl/bta_pkg.sv @@
// shared types, codes and sizes for the transaction id allocator
`default_nettype none

package bta_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int KEY_W    = 64;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic OP_ASSIGN  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] block_key;
    logic [ID_W-1:0]  slot_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     assigned_id;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } out_item_t;

  typedef struct packed {
    logic             in_use;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

endpackage

`default_nettype wire

@@ rtl/bta_if.sv @@
// request and response channel interfaces
`default_nettype none

interface bta_in_if;
  logic              valid;
  logic              ready;
  bta_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bta_out_if;
  logic               valid;
  logic               ready;
  bta_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/block_transaction_id_allocator_top.sv @@
// transaction id allocator: free list fifo plus a keyed slot table searched serially
//
// After reset the block runs a clearing pass, one entry per cycle, that marks every slot
// free and loads the free list with ids 0..ENTRIES-1; no request is taken during it.
// An assign request walks the slot table through one compare unit, one slot per cycle
// behind a registered memory read. A miss scans every slot, then takes one allocate step
// and then posts the result; a hit ends the scan early. A release reads the named slot,
// updates it, then posts the result. One request is in flight at a time; the result sits
// in an output register, and the next request is taken while it waits to be drained.
// Ids are reported in 6 bits and the free count in 7 bits.
`default_nettype none

module block_transaction_id_allocator_top #(
  parameter int ENTRIES = bta_pkg::ENTRIES_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bta_in_if.sink     request,
  bta_out_if.source  response
);

  localparam int IDW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int CW   = IDW + 1;
  localparam int WIDE = (IDW > bta_pkg::ID_W) ? IDW : bta_pkg::ID_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // storage
  bta_pkg::slot_entry_t slot_mem [ENTRIES];
  logic [IDW-1:0]       free_list [ENTRIES];

  // control registers
  logic [2:0]     state, state_next;
  logic [CW-1:0]  cnt, cnt_next;          // clear index and scan issue index
  logic           rd_pending, rd_pending_next;
  logic [IDW-1:0] rd_idx, rd_idx_next;
  logic [IDW-1:0] head, head_next;
  logic [IDW-1:0] tail, tail_next;
  logic [FW-1:0]  fill, fill_next;
  logic           out_valid, out_valid_next;

  // request payload held for the whole item
  logic                           op;
  logic [bta_pkg::KEY_W-1:0]      key;
  logic [IDW-1:0]                 sid_addr;
  logic                           sid_ok;
  logic [bta_pkg::ID_W-1:0]       sid;

  // result waiting for the output register
  logic [IDW-1:0]                 res_id, res_id_next;
  logic [bta_pkg::STATUS_W-1:0]   res_status, res_status_next;

  bta_pkg::out_item_t out_data;

  // memory ports
  bta_pkg::slot_entry_t slot_rd;
  bta_pkg::slot_entry_t slot_wdata;
  logic [IDW-1:0]       slot_raddr, slot_waddr;
  logic                 slot_we;
  logic [IDW-1:0]       fl_rd;
  logic [IDW-1:0]       fl_waddr, fl_wdata;
  logic                 fl_we;

  // release id mapped into the table's index range
  logic [WIDE:0]        req_sid_w;
  logic                 req_sid_ok;
  logic [IDW-1:0]       req_sid_addr;
  logic                 accept;
  logic                 can_post;
  logic                 hit;

  assign req_sid_w    = (WIDE + 1)'(request.data.slot_id);
  assign req_sid_ok   = req_sid_w < (WIDE + 1)'(ENTRIES);
  assign req_sid_addr = req_sid_w[IDW-1:0];

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign can_post      = !out_valid || response.ready;
  assign hit           = rd_pending && slot_rd.in_use && (slot_rd.key == key);

  assign response.valid = out_valid;
  assign response.data  = out_data;

  // slot table read address: named slot on a release, scan index otherwise
  always_comb begin
    if (state == S_IDLE) begin
      slot_raddr = req_sid_addr;
    end else begin
      slot_raddr = cnt[IDW-1:0];
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    rd_pending_next = 1'b0;
    rd_idx_next     = rd_idx;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    out_valid_next  = out_valid && !response.ready;
    res_id_next     = res_id;
    res_status_next = res_status;
    slot_we         = 1'b0;
    slot_waddr      = cnt[IDW-1:0];
    slot_wdata      = '0;
    fl_we           = 1'b0;
    fl_waddr        = cnt[IDW-1:0];
    fl_wdata        = cnt[IDW-1:0];

    unique case (state)
      S_CLEAR: begin
        // one entry per cycle: slot free, free list holds its own index
        slot_we  = 1'b1;
        fl_we    = 1'b1;
        cnt_next = cnt + CW'(1);
        if (cnt == CW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if (request.data.operation == bta_pkg::OP_ASSIGN) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_REL;
          end
        end
      end
      S_SCAN: begin
        // compare the slot read last cycle, issue the read of the next one
        if (hit) begin
          res_id_next     = rd_idx;
          res_status_next = bta_pkg::ST_FOUND;
          state_next      = S_DONE;
        end else if (cnt < CW'(ENTRIES)) begin
          rd_pending_next = 1'b1;
          rd_idx_next     = cnt[IDW-1:0];
          cnt_next        = cnt + CW'(1);
        end else if (!rd_pending) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (fill == '0) begin
          res_id_next     = '0;
          res_status_next = bta_pkg::ST_FULL;
        end else begin
          res_id_next     = fl_rd;
          res_status_next = bta_pkg::ST_NEW;
          head_next       = (head == IDW'(ENTRIES - 1)) ? '0 : head + IDW'(1);
          fill_next       = fill - FW'(1);
          slot_we         = 1'b1;
          slot_waddr      = fl_rd;
          slot_wdata      = '{in_use: 1'b1, key: key};
        end
        state_next = S_DONE;
      end
      S_REL: begin
        res_id_next = sid_addr;
        if (!sid_ok || !slot_rd.in_use) begin
          res_status_next = bta_pkg::ST_NOT_IN_USE;
        end else begin
          res_status_next = bta_pkg::ST_RELEASED;
          slot_we         = 1'b1;
          slot_waddr      = sid_addr;
          slot_wdata      = '0;
          if (fill < FW'(ENTRIES)) begin
            fl_we     = 1'b1;
            fl_waddr  = tail;
            fl_wdata  = sid_addr;
            tail_next = (tail == IDW'(ENTRIES - 1)) ? '0 : tail + IDW'(1);
            fill_next = fill + FW'(1);
          end
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (can_post) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      rd_pending <= 1'b0;
      head       <= '0;
      tail       <= '0;
      fill       <= FW'(ENTRIES);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rd_pending <= rd_pending_next;
      head       <= head_next;
      tail       <= tail_next;
      fill       <= fill_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    if (accept) begin
      op       <= request.data.operation;
      key      <= request.data.block_key;
      sid      <= request.data.slot_id;
      sid_addr <= req_sid_addr;
      sid_ok   <= req_sid_ok;
    end
    if (state == S_DONE && can_post) begin
      // a release always echoes the 6-bit id it was given
      if (op == bta_pkg::OP_RELEASE) begin
        out_data.assigned_id <= sid;
      end else begin
        out_data.assigned_id <= bta_pkg::ID_W'(res_id);
      end
      out_data.status     <= res_status;
      out_data.free_count <= bta_pkg::COUNT_W'(fill);
    end
  end

  // slot table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd <= slot_mem[slot_raddr];
  end

  // free list: write at tail (or clear index), registered read at head
  always_ff @(posedge clk) begin
    if (fl_we) begin
      free_list[fl_waddr] <= fl_wdata;
    end
    fl_rd <= free_list[head];
  end

endmodule

`default_nettype wire

@@ sim/block_transaction_id_allocator_top_tb.sv @@
// self-checking testbench for the transaction id allocator
`default_nettype none

module block_transaction_id_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bta_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  // slowest item: full table walk plus the widest sender gap and receiver stall, many times over
  localparam int CYCLE_LIMIT = 250000;
  localparam int KEY_POOL = 96;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;

  logic clk;
  logic rst = 1'b1;

  bta_in_if  request_ch ();
  bta_out_if response_ch ();

  block_transaction_id_allocator_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch.sink),
    .response (response_ch.source)
  );

  // shadow copy of the allocator state, advanced once per accepted request
  logic [ID_W-1:0]  free_ids [ENTRIES];
  int unsigned      free_rd;
  int unsigned      free_wr;
  int unsigned      free_cnt;
  bit               slot_busy [ENTRIES];
  logic [KEY_W-1:0] slot_key [ENTRIES];

  // results owed by the block, oldest first
  out_item_t pending_results [$];

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned hold_off = 0;

  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen [5];

  // clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hang anywhere ends the run as a failure
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // predicted outcome of one request; updates the shadow state
  function automatic out_item_t predict_allocation(in_item_t req);
    out_item_t   res;
    int          hit;
    int unsigned id;
    int          i;
    hit = -1;
    if (req.operation == OP_ASSIGN) begin
      // only busy slots take part in the lookup, stale keys in free slots never hit
      for (i = ENTRIES - 1; i >= 0; i--) begin
        if (slot_busy[i] && slot_key[i] == req.block_key) hit = i;
      end
      if (hit >= 0) begin
        res.assigned_id = hit[ID_W-1:0];
        res.status      = ST_FOUND;
      end else if (free_cnt == 0) begin
        res.assigned_id = '0;
        res.status      = ST_FULL;
      end else begin
        id = 32'(free_ids[free_rd]);
        free_rd = (free_rd + 1) % ENTRIES;
        free_cnt--;
        slot_busy[id]   = 1'b1;
        slot_key[id]    = req.block_key;
        res.assigned_id = id[ID_W-1:0];
        res.status      = ST_NEW;
      end
    end else begin
      res.assigned_id = req.slot_id;
      if (req.slot_id >= ENTRIES || !slot_busy[req.slot_id]) begin
        res.status = ST_NOT_IN_USE;
      end else begin
        slot_busy[req.slot_id] = 1'b0;
        slot_key[req.slot_id]  = '0;
        if (free_cnt < ENTRIES) begin
          free_ids[free_wr] = req.slot_id;
          free_wr = (free_wr + 1) % ENTRIES;
          free_cnt++;
        end
        res.status = ST_RELEASED;
      end
    end
    res.free_count = free_cnt[COUNT_W-1:0];
    return res;
  endfunction

  // random busy slot, or -1 when the table is empty
  function automatic int pick_busy_slot();
    int busy [$];
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (slot_busy[i]) busy.push_back(i);
    end
    if (busy.size() == 0) return -1;
    return busy[$urandom_range(0, busy.size() - 1)];
  endfunction

  // one request beat; valid is left high so back-to-back beats need no gap
  task automatic issue_request(logic op, logic [KEY_W-1:0] key, logic [ID_W-1:0] sid);
    in_item_t item;
    int       gap;
    item.operation = op;
    item.block_key = key;
    item.slot_id   = sid;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.data  <= item;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    pending_results.push_back(predict_allocation(item));
    requests_sent++;
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    request_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatches < 10) begin
      $display("mismatch at cycle %0d, beat %0d: %s expected %0d got %0d",
               cycle_count, beats_checked, what, want, got);
    end
    mismatches++;
  endtask

  // response sink: random stall per beat, or one long hold-off when asked
  initial begin
    int stall;
    response_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (hold_off > 0) begin
        stall = hold_off;
        hold_off = 0;
      end
      if (stall > 0) begin
        response_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      response_ch.ready <= 1'b1;
      @(posedge clk);
      while (!response_ch.valid) @(posedge clk);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && response_ch.valid && response_ch.ready) begin
      got = response_ch.data;
      if (got.status < 5) status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected beat, status", 0, 32'(got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.assigned_id !== want.assigned_id)
          flag_mismatch("assigned_id", 32'(want.assigned_id), 32'(got.assigned_id));
        if (got.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.free_count !== want.free_count)
          flag_mismatch("free_count", 32'(want.free_count), 32'(got.free_count));
      end
      beats_checked++;
    end
  end

  // extreme keys, zero-key stale slots, double release and release of free ids
  task automatic test_key_extremes();
    issue_request(OP_ASSIGN, '0, 6'h3f);           // zero key must not hit a free slot
    issue_request(OP_ASSIGN, '1, 6'h00);
    issue_request(OP_ASSIGN, '0, 6'h15);           // hit on slot 0
    issue_request(OP_ASSIGN, '1, 6'h2a);           // hit on slot 1
    issue_request(OP_ASSIGN, 64'h8000_0000_0000_0001, 6'h00);
    issue_request(OP_RELEASE, 64'h5555_5555_5555_5555, 6'h3f);  // never bound
    issue_request(OP_RELEASE, '1, 6'h00);
    issue_request(OP_ASSIGN, '0, 6'h00);           // old key gone, released id sits at the tail
    issue_request(OP_RELEASE, 64'haaaa_aaaa_aaaa_aaaa, 6'h00);  // slot 0 already free
    issue_request(OP_RELEASE, '0, 6'h02);
    issue_request(OP_ASSIGN, 64'h8000_0000_0000_0001, 6'h3f);   // freed key binds afresh
    issue_request(OP_RELEASE, '0, 6'h2a);
    issue_request(OP_RELEASE, '1, 6'h15);
    settle();
  endtask

  // bind every id, hit the full table, then recycle one slot
  task automatic test_table_full();
    int victim;
    while (free_cnt > 0)
      issue_request(OP_ASSIGN, {$urandom(), $urandom()}, ID_W'($urandom()));
    issue_request(OP_ASSIGN, {$urandom(), $urandom()}, ID_W'($urandom()));
    issue_request(OP_ASSIGN, 64'hdead_beef_0000_0001, ID_W'($urandom()));
    victim = pick_busy_slot();
    // lookup still hits when full
    issue_request(OP_ASSIGN, slot_key[victim], ID_W'($urandom()));
    issue_request(OP_RELEASE, {$urandom(), $urandom()}, ID_W'(victim));
    issue_request(OP_ASSIGN, {$urandom(), $urandom()}, ID_W'($urandom()));
    settle();
  endtask

  // receiver holds off while requests keep coming, so the block stalls its input
  task automatic test_backpressure();
    int victim;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off = 300;
    repeat (4) begin
      victim = pick_busy_slot();
      issue_request(OP_RELEASE, {$urandom(), $urandom()},
                    victim < 0 ? 6'd0 : ID_W'(victim));
      issue_request(OP_RELEASE, {$urandom(), $urandom()}, ID_W'($urandom()));
    end
    issue_request(OP_ASSIGN, {$urandom(), $urandom()}, ID_W'($urandom()));
    issue_request(OP_ASSIGN, key_pool[0], ID_W'($urandom()));
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // mixed traffic; assign_pct steers the table toward full or empty
  task automatic test_random_traffic(int unsigned count, int unsigned assign_pct);
    int unsigned roll;
    int          victim;
    int unsigned n;
    for (n = 0; n < count; n++) begin
      // idle pattern changes every 40 beats, including stretches with none
      if (n % 40 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < assign_pct) begin
        // mostly reused keys so hits and a full table both happen
        if ($urandom_range(0, 9) == 0)
          issue_request(OP_ASSIGN, {$urandom(), $urandom()}, ID_W'($urandom()));
        else
          issue_request(OP_ASSIGN, key_pool[$urandom_range(0, KEY_POOL - 1)],
                        ID_W'($urandom()));
      end else begin
        victim = pick_busy_slot();
        // some releases name arbitrary ids, free ones included
        if (victim < 0 || $urandom_range(0, 7) == 0)
          issue_request(OP_RELEASE, {$urandom(), $urandom()}, ID_W'($urandom()));
        else
          issue_request(OP_RELEASE, {$urandom(), $urandom()}, ID_W'(victim));
      end
    end
    settle();
  endtask

  initial begin
    int i;
    request_ch.valid <= 1'b0;
    request_ch.data  <= '0;

    // shadow state after reset: all ids free, in order
    for (i = 0; i < ENTRIES; i++) begin
      free_ids[i]  = ID_W'(i);
      slot_busy[i] = 1'b0;
      slot_key[i]  = '0;
    end
    free_rd  = 0;
    free_wr  = 0;
    free_cnt = ENTRIES;
    for (i = 0; i < 5; i++) status_seen[i] = 0;

    // key pool with both extremes in it
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom(), $urandom()};

    // synchronous reset first; the block then clears its tables on its own
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_extremes();
    test_table_full();
    test_backpressure();
    test_random_traffic(110, 30);
    test_random_traffic(110, 70);
    test_random_traffic(100, 50);

    // let any late or extra beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d checked responses in %0d cycles",
             requests_sent, beats_checked, cycle_count);
    $display("responses by kind: found %0d, new %0d, full %0d, released %0d, not in use %0d",
             status_seen[ST_FOUND], status_seen[ST_NEW], status_seen[ST_FULL],
             status_seen[ST_RELEASED], status_seen[ST_NOT_IN_USE]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
